>>> hdl/rmv_pkg.sv
// Shared types and constants for the rolling momentum / volatility scorer.
// No dependencies; every other file refers to it by scoped names.
package rmv_pkg;

    localparam int PRICE_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 18;
    localparam int WIDE_W       = 128;
    localparam int SCALE_W      = 35;
    localparam int QUEUE_DEPTH  = 2;

    localparam int MAX_LOOKBACK_DEF = 256;
    localparam int VOL_WINDOW_DEF   = 20;

    // 252 trading days times 10^8 (hundredths of a percent, squared)
    localparam logic [SCALE_W-1:0] ANNUAL_SCALE = 35'd25200000000;
    // one in thousandths of a percent
    localparam logic signed [19:0] PCT_ONE = 20'sd100000;
    // 1.0 in Q2.30 and the saturated return
    localparam logic [31:0] RET_ONE = 32'h4000_0000;
    localparam logic [31:0] RET_SAT = 32'h7FFF_FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOM_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_LONG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_LIM  = 3'd5;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               start;
    } item_t;

    typedef struct packed {
        logic               mom_en;
        logic               dir_long;
        logic [8:0]         lookback;
        logic signed [17:0] thr;
        logic               vol_en;
        logic [16:0]        vol_lim;
    } cfg_t;

endpackage

>>> hdl/rmv_front.sv
// Front end: accepts bars and holds them in a two-entry queue for the back end.
// Depends on rmv_pkg.
module rmv_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rmv_pkg::PRICE_W-1:0]   open_price,
    input  logic                          series_start,
    output logic                          q_valid,
    output rmv_pkg::item_t                q_item,
    input  logic                          q_pop
);

    rmv_pkg::item_t fifo_mem [rmv_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_stall = (count_reg == 2'(rmv_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{price: open_price, start: series_start};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> hdl/rmv_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, 128-bit product.
// Depends on rmv_pkg.
module rmv_mul #(
    parameter int B_W = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rmv_pkg::WIDE_W-1:0]  a,
    input  logic [B_W-1:0]              b,
    output logic [rmv_pkg::WIDE_W-1:0]  product,
    output logic                        done
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [rmv_pkg::WIDE_W-1:0] acc_reg;
    logic [rmv_pkg::WIDE_W-1:0] m_reg;
    logic [B_W-1:0]             b_reg;
    logic [CNT_W-1:0]           cnt_reg;

    assign product = acc_reg;
    assign done    = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(B_W);
        end
        else if (!done)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            m_reg   <= a;
            b_reg   <= b;
        end
        else if (!done)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + m_reg;
            end
            m_reg <= m_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

>>> hdl/rmv_div.sv
// Restoring divider for (cur << 30) / prev, one quotient bit per cycle.
// Caller guarantees cur < 3 * prev, so the quotient fits 32 bits. Depends on rmv_pkg.
module rmv_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rmv_pkg::PRICE_W-1:0] cur,
    input  logic [rmv_pkg::PRICE_W-1:0] prev,
    output logic [31:0]                 quotient,
    output logic                        done
);

    logic [31:0] rem_reg;
    logic [31:0] lo_reg;
    logic [31:0] d_reg;
    logic [31:0] q_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;
    logic        fits;

    assign done     = (cnt_reg == 6'd0);
    assign quotient = q_reg;
    assign trial    = {rem_reg, lo_reg[31]};
    assign fits     = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (!done)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, cur[31:2]};
            lo_reg  <= {cur[1:0], 30'b0};
            d_reg   <= prev;
            q_reg   <= '0;
        end
        else if (!done)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[30:0], fits};
        end
    end

endmodule

>>> hdl/rmv_back.sv
// Back end: sequencer that scores one bar, price and return memories, running sums.
// Depends on rmv_pkg, rmv_mul, rmv_div.
module rmv_back #(
    parameter int MAX_LOOKBACK = rmv_pkg::MAX_LOOKBACK_DEF,
    parameter int VOL_WINDOW   = rmv_pkg::VOL_WINDOW_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rmv_pkg::item_t q_item,
    output logic           q_pop,
    input  rmv_pkg::cfg_t  cfg,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     score,
    output logic           momentum_hit,
    output logic           volatility_hit
);

    localparam int HD      = MAX_LOOKBACK + 1;
    localparam int HP_W    = $clog2(HD);
    localparam int LB_W    = $clog2(MAX_LOOKBACK + 1);
    localparam int WP_W    = $clog2(VOL_WINDOW);
    localparam int SUM_W   = 32 + $clog2(VOL_WINDOW);
    localparam int SQ_W    = 54 + $clog2(VOL_WINDOW);
    localparam int MB_W    = (SUM_W > rmv_pkg::SCALE_W) ? SUM_W : rmv_pkg::SCALE_W;
    localparam int W_SCALE = VOL_WINDOW * 256;
    localparam int WW      = VOL_WINDOW * (VOL_WINDOW - 1);
    localparam int WD      = rmv_pkg::WIDE_W;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_RDN  = 15'h0002,
        S_RDO  = 15'h0004,
        S_MOM1 = 15'h0008,
        S_MOM2 = 15'h0010,
        S_VSQ  = 15'h0020,
        S_VSQW = 15'h0040,
        S_VN   = 15'h0080,
        S_VLW  = 15'h0100,
        S_DIV  = 15'h0200,
        S_DIVW = 15'h0400,
        S_SQN  = 15'h0800,
        S_SQO  = 15'h1000,
        S_UPD  = 15'h2000,
        S_SPARE = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // memories
    logic [31:0]        price_mem [HD];
    logic signed [31:0] win_mem   [VOL_WINDOW];
    logic [31:0]        hist_rd_reg;
    logic signed [31:0] win_rd_reg;
    logic [HP_W-1:0]    hist_raddr;

    // control state
    logic [HP_W-1:0]    hist_pos_reg;
    logic [WP_W-1:0]    win_pos_reg;
    logic [15:0]        bars_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]    sq_sum_reg;
    logic               out_valid_reg;

    // per-bar payload
    logic [31:0]        cur_reg;
    logic [31:0]        newest_reg;
    logic signed [31:0] old_reg;
    logic signed [52:0] c_reg;
    logic signed [52:0] p_reg;
    logic               oldp_nz_reg;
    logic               mom_reg;
    logic               vol_reg;
    logic [WD-1:0]      a_reg;
    logic [WD-1:0]      n_reg;
    logic [WD-1:0]      rhs_reg;
    logic [33:0]        limsq_reg;
    logic signed [31:0] r_reg;
    logic [53:0]        sqn_reg;
    logic [53:0]        sqo_reg;
    logic [1:0]         score_reg;
    logic               mom_out_reg;
    logic               vol_out_reg;

    // combinational helpers
    logic [LB_W-1:0]    leff;
    logic [HP_W:0]      old_tmp;
    logic [HP_W-1:0]    old_addr;
    logic [HP_W-1:0]    newest_addr;
    logic               mom_ok;
    logic               vol_ok;
    logic               old_filled;
    logic signed [19:0] fac;
    logic signed [52:0] p_next;
    logic signed [52:0] c_next;
    logic [SUM_W-1:0]   s1_abs;
    logic               mul_start;
    logic [WD-1:0]      mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [WD-1:0]      mul_p;
    logic               mul_done;
    logic               div_start;
    logic [31:0]        div_q;
    logic               div_done;
    logic               ret_live;
    logic               ret_sat;
    logic signed [31:0] sq_src;
    logic [30:0]        sq_mag;
    logic [61:0]        sq_full;
    logic [49:0]        rhs_x;
    logic               pop;
    logic               out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop    = pop;

    // effective lookback clamped to 1..MAX_LOOKBACK
    always_comb
    begin
        if (cfg.lookback == 9'd0)
        begin
            leff = LB_W'(1);
        end
        else if (32'(cfg.lookback) > 32'(MAX_LOOKBACK))
        begin
            leff = LB_W'(MAX_LOOKBACK);
        end
        else
        begin
            leff = LB_W'(cfg.lookback);
        end
    end

    assign newest_addr = (hist_pos_reg == '0) ? HP_W'(HD - 1) : hist_pos_reg - HP_W'(1);
    assign old_tmp     = {1'b0, hist_pos_reg} + (HP_W + 1)'(HD - 1) - (HP_W + 1)'(leff);
    assign old_addr    = (old_tmp >= (HP_W + 1)'(HD)) ?
                         HP_W'(old_tmp - (HP_W + 1)'(HD)) : old_tmp[HP_W-1:0];
    assign hist_raddr  = (state_reg == S_RDO) ? old_addr : newest_addr;

    assign mom_ok     = ({1'b0, bars_reg} >= (17'(leff) + 17'd1));
    assign vol_ok     = (32'(bars_reg) >= 32'(VOL_WINDOW + 1));
    assign old_filled = (32'(bars_reg) >= 32'(VOL_WINDOW));

    // momentum products
    assign fac    = cfg.dir_long ? (rmv_pkg::PCT_ONE + 20'(cfg.thr))
                                 : (rmv_pkg::PCT_ONE - 20'(cfg.thr));
    assign p_next = $signed({21'b0, hist_rd_reg}) * 53'(fac);
    assign c_next = $signed({21'b0, newest_reg}) * 53'(rmv_pkg::PCT_ONE);

    // volatility multiplier operands
    assign s1_abs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mul_start = (state_reg == S_VSQ) || (state_reg == S_VN);
    assign mul_a     = (state_reg == S_VN) ? n_reg : WD'(s1_abs);
    assign mul_b     = (state_reg == S_VN) ? MB_W'(rmv_pkg::ANNUAL_SCALE) : MB_W'(s1_abs);
    assign rhs_x     = 50'(limsq_reg) * 50'(WW);

    // return
    assign ret_live  = (bars_reg != 16'd0) && (newest_reg != 32'd0);
    assign ret_sat   = ({2'b00, cur_reg} >= ({2'b00, newest_reg} + {1'b0, newest_reg, 1'b0}));
    assign div_start = (state_reg == S_DIV) && ret_live && !ret_sat;

    // squared return terms, Q.52
    assign sq_src  = (state_reg == S_SQO) ? old_reg : r_reg;
    assign sq_mag  = sq_src[31] ? 31'(-sq_src) : sq_src[30:0];
    assign sq_full = 62'(sq_mag) * 62'(sq_mag);

    rmv_mul #(.B_W(MB_W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    rmv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .cur      (cur_reg),
        .prev     (newest_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (pop) state_next = S_RDN;
            S_RDN:   state_next = S_RDO;
            S_RDO:   state_next = S_MOM1;
            S_MOM1:  state_next = S_MOM2;
            S_MOM2:  state_next = (cfg.vol_en && vol_ok) ? S_VSQ : S_DIV;
            S_VSQ:   state_next = S_VSQW;
            S_VSQW:  if (mul_done) state_next = S_VN;
            S_VN:    state_next = S_VLW;
            S_VLW:   if (mul_done) state_next = S_DIV;
            S_DIV:   state_next = div_start ? S_DIVW : S_SQN;
            S_DIVW:  if (div_done) state_next = S_SQN;
            S_SQN:   state_next = S_SQO;
            S_SQO:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            price_mem[hist_pos_reg] <= cur_reg;
        end
        hist_rd_reg <= price_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            win_mem[win_pos_reg] <= r_reg;
        end
        win_rd_reg <= win_mem[win_pos_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hist_pos_reg  <= '0;
            win_pos_reg   <= '0;
            bars_reg      <= '0;
            sum_reg       <= '0;
            sq_sum_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && q_item.start)
            begin
                // new series: history empties by fill count, no sweep
                hist_pos_reg <= '0;
                win_pos_reg  <= '0;
                bars_reg     <= '0;
                sum_reg      <= '0;
                sq_sum_reg   <= '0;
            end
            if (state_reg == S_UPD)
            begin
                sum_reg    <= sum_reg + SUM_W'(r_reg) - SUM_W'(old_reg);
                sq_sum_reg <= SQ_W'((SQ_W + 1)'(sq_sum_reg) + (SQ_W + 1)'(sqn_reg)
                                    - (SQ_W + 1)'(sqo_reg));
                win_pos_reg  <= (win_pos_reg == WP_W'(VOL_WINDOW - 1)) ?
                                '0 : win_pos_reg + WP_W'(1);
                hist_pos_reg <= (hist_pos_reg == HP_W'(HD - 1)) ?
                                '0 : hist_pos_reg + HP_W'(1);
                if (bars_reg != 16'hFFFF)
                begin
                    bars_reg <= bars_reg + 16'd1;
                end
                out_valid_reg <= 1'b1;
            end
        end
    end

    // per-bar datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cur_reg <= q_item.price;
            end
            S_RDO:
            begin
                newest_reg <= hist_rd_reg;
                old_reg    <= old_filled ? win_rd_reg : 32'sd0;
            end
            S_MOM1:
            begin
                c_reg       <= c_next;
                p_reg       <= p_next;
                oldp_nz_reg <= (hist_rd_reg != 32'd0);
            end
            S_MOM2:
            begin
                mom_reg <= cfg.mom_en && mom_ok && oldp_nz_reg &&
                           (cfg.dir_long ? (c_reg > p_reg) : (c_reg < p_reg));
                vol_reg <= 1'b0;
            end
            S_VSQ:
            begin
                a_reg     <= WD'(sq_sum_reg) * WD'(W_SCALE);
                limsq_reg <= 34'(cfg.vol_lim) * 34'(cfg.vol_lim);
            end
            S_VSQW:
            begin
                if (mul_done)
                begin
                    n_reg   <= (a_reg > mul_p) ? (a_reg - mul_p) : '0;
                    rhs_reg <= WD'(rhs_x) << 60;
                end
            end
            S_VLW:
            begin
                if (mul_done)
                begin
                    vol_reg <= (mul_p < rhs_reg);
                end
            end
            S_DIV:
            begin
                if (!ret_live)
                begin
                    r_reg <= 32'sd0;
                end
                else if (ret_sat)
                begin
                    r_reg <= $signed(rmv_pkg::RET_SAT);
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    r_reg <= $signed(div_q - rmv_pkg::RET_ONE);
                end
            end
            S_SQN:
            begin
                sqn_reg <= sq_full[61:8];
            end
            S_SQO:
            begin
                sqo_reg <= sq_full[61:8];
            end
            S_UPD:
            begin
                score_reg   <= {1'b0, mom_reg} + {1'b0, vol_reg};
                mom_out_reg <= mom_reg;
                vol_out_reg <= vol_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign score          = score_reg;
    assign momentum_hit   = mom_out_reg;
    assign volatility_hit = vol_out_reg;

endmodule

>>> hdl/rolling_momentum_volatility_signal.sv
// Rolling momentum / low-volatility signal scorer: top level with config registers.
// Depends on rmv_pkg, rmv_front, rmv_back (and through it rmv_mul, rmv_div).
//
// One open price per bar (unsigned Q16.16) goes in, one score comes out for
// that bar, built only from earlier bars of the same series. Momentum fires
// when the return over the configured lookback clears momentum_threshold in the
// configured direction; the volatility filter fires when the annualized
// sample deviation of the last VOL_WINDOW one-bar returns is below
// volatility_limit, tested in squared form. A bar with series_start set
// empties all history first. Bars are taken into a two-entry queue while the
// back end works, so the input side can still take up to two bars while a
// result waits on a stalled output. The back end scores one bar at a time:
// sequencing from idle through the update, plus the one-bit-per-cycle
// divider when a one-bar return has to be computed, plus the two shift-add
// multiplies when the volatility filter is enabled and the window is full.
// The price history lives in a (MAX_LOOKBACK + 1)-entry memory that is
// emptied by its fill count, so no clearing pass follows reset. Config is
// written on cfg_index/cfg_data when cfg_valid is high (cfg_ready is always
// high); unknown indexes are dropped. Write config only while no bar is in
// flight.
module rolling_momentum_volatility_signal #(
    parameter int MAX_LOOKBACK = rmv_pkg::MAX_LOOKBACK_DEF,
    parameter int VOL_WINDOW   = rmv_pkg::VOL_WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // bar input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rmv_pkg::PRICE_W-1:0]     open_price,
    input  logic                            series_start,
    // score output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      score,
    output logic                            momentum_hit,
    output logic                            volatility_hit,
    // config writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rmv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rmv_pkg::cfg_t  cfg_reg;
    rmv_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    // config register file; values are masked to field width as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mom_en   <= 1'b1;
            cfg_reg.dir_long <= 1'b1;
            cfg_reg.lookback <= 9'd1;
            cfg_reg.thr      <= 18'sd500;
            cfg_reg.vol_en   <= 1'b0;
            cfg_reg.vol_lim  <= 17'd2500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rmv_pkg::CFG_MOM_EN:   cfg_reg.mom_en   <= cfg_data[0];
                rmv_pkg::CFG_DIR_LONG: cfg_reg.dir_long <= cfg_data[0];
                rmv_pkg::CFG_LOOKBACK: cfg_reg.lookback <= cfg_data[8:0];
                rmv_pkg::CFG_THRESH:   cfg_reg.thr      <= $signed(cfg_data[17:0]);
                rmv_pkg::CFG_VOL_EN:   cfg_reg.vol_en   <= cfg_data[0];
                rmv_pkg::CFG_VOL_LIM:  cfg_reg.vol_lim  <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: accept and queue bars
    rmv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .open_price   (open_price),
        .series_start (series_start),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // back: score one bar at a time, hold result in the output register
    rmv_back #(
        .MAX_LOOKBACK (MAX_LOOKBACK),
        .VOL_WINDOW   (VOL_WINDOW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .cfg            (cfg_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .score          (score),
        .momentum_hit   (momentum_hit),
        .volatility_hit (volatility_hit)
    );

endmodule
